### hw/rtl/d3bl_pkg.sv
// Shared types, constants and arithmetic helpers of the DOT3 light vector core.
`timescale 1ns / 1ps
package d3bl_pkg;

	typedef logic [2:0] cfg_idx_t;

	localparam cfg_idx_t REG_LIGHT_X   = 3'd0;
	localparam cfg_idx_t REG_LIGHT_Y   = 3'd1;
	localparam cfg_idx_t REG_LIGHT_Z   = 3'd2;
	localparam cfg_idx_t REG_VIEWER_X  = 3'd3;
	localparam cfg_idx_t REG_VIEWER_Y  = 3'd4;
	localparam cfg_idx_t REG_VIEWER_Z  = 3'd5;
	localparam cfg_idx_t REG_SHININESS = 3'd6;

	localparam logic [16:0] SHIN_RESET = 17'd65536;
	localparam logic [7:0]  GREY_BYTE  = 8'h80;
	localparam logic [7:0]  BYTE_MAX   = 8'hFF;
	localparam logic [5:0]  NORM_MSB   = 6'd20;

	localparam int SQ_W       = 46;
	localparam int SQ_STAGES  = 11;
	localparam int DIV_STAGES = 9;

	typedef struct packed {
		logic [47:0] nrm;
		logic [47:0] tan;
		logic [47:0] bin;
		logic        last;
	} side_t;

	typedef struct packed {
		logic [2:0]        neg;
		logic              zero;
		logic [2:0][20:0]  a;
	} lane_t;

	typedef struct packed {
		logic [SQ_W-1:0] n;
		logic [SQ_W-1:0] res;
	} root_t;

	typedef struct packed {
		logic [2:0]        neg;
		logic              zero;
		logic [22:0]       len;
		logic [2:0][39:0]  rem;
		logic [2:0][16:0]  q;
	} quo_t;

	function automatic logic [5:0] msb_pos(input logic [32:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 33; i++) begin
			if (v[i]) p = 6'(i);
		end
		return p;
	endfunction

	function automatic root_t root_step(input root_t s, input logic [SQ_W-1:0] b);
		root_t r;
		logic [SQ_W-1:0] t;
		t = s.res + b;
		if (s.n >= t) begin
			r.n   = s.n - t;
			r.res = (s.res >> 1) + b;
		end else begin
			r.n   = s.n;
			r.res = s.res >> 1;
		end
		return r;
	endfunction

	function automatic quo_t div_step(input quo_t x, input int unsigned sh);
		quo_t r;
		logic [39:0] d;
		r = x;
		d = 40'(x.len) << sh;
		for (int i = 0; i < 3; i++) begin
			if (x.rem[i] >= d) begin
				r.rem[i] = x.rem[i] - d;
				r.q[i]   = x.q[i] | (17'(1) << sh);
			end
		end
		return r;
	endfunction

	// t carries 30 fraction bits
	function automatic logic [7:0] diff_byte(input logic signed [43:0] t);
		if (t[43]) return 8'h00;
		if (|t[42:38]) return BYTE_MAX;
		return t[37:30];
	endfunction

	// t carries 48 fraction bits
	function automatic logic [7:0] spec_byte(input logic signed [57:0] t);
		if (t[57]) return 8'h00;
		if (t[56]) return BYTE_MAX;
		return t[55:48];
	endfunction

endpackage

### hw/rtl/dot3_bump_light_vector_core.sv
// Pipelined DOT3 tangent-space light and half vector unit, one vertex per clock while a stage is free.
// Accepts one vertex per clock while any stage is free and returns its colors (the vector
// normalization uses eleven square-root stages resolving two root bits each and nine divider
// stages resolving two quotient bits each except the last, which resolves one). A stalled
// output freezes only the stages that are full, so bubbles close up and the input keeps
// accepting while any slot is free.
// Configuration registers are read live and must be written only while the pipe is empty.
`timescale 1ns / 1ps
module dot3_bump_light_vector_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [47:0]        normal_xyz,
	input  logic [47:0]        tangent_xyz,
	input  logic [47:0]        binormal_xyz,
	input  logic               last_vertex,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         diffuse_r,
	output logic [7:0]         diffuse_g,
	output logic [7:0]         diffuse_b,
	output logic [7:0]         specular_r,
	output logic [7:0]         specular_g,
	output logic [7:0]         specular_b,
	output logic               lit,
	output logic               last_out,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int S_DIFF  = 1;
	localparam int S_POS   = 2;
	localparam int S_SHIFT = 3;
	localparam int S_SQR   = 4;
	localparam int S_SUM   = 5;
	localparam int S_ROOT0 = 6;
	localparam int S_DIV0  = S_ROOT0 + d3bl_pkg::SQ_STAGES;
	localparam int S_UNIT  = S_DIV0 + d3bl_pkg::DIV_STAGES;
	localparam int S_MUL   = S_UNIT + 1;
	localparam int S_DOT   = S_MUL + 1;
	localparam int S_SCALE = S_DOT + 1;
	localparam int S_OUT   = S_SCALE + 1;
	localparam int NS      = S_OUT;

	// configuration
	logic signed [31:0] light_q  [3];
	logic signed [31:0] viewer_q [3];
	logic [16:0]        shin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				light_q[i]  <= '0;
				viewer_q[i] <= '0;
			end
			shin_q <= d3bl_pkg::SHIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				d3bl_pkg::REG_LIGHT_X:   light_q[0]  <= cfg_data;
				d3bl_pkg::REG_LIGHT_Y:   light_q[1]  <= cfg_data;
				d3bl_pkg::REG_LIGHT_Z:   light_q[2]  <= cfg_data;
				d3bl_pkg::REG_VIEWER_X:  viewer_q[0] <= cfg_data;
				d3bl_pkg::REG_VIEWER_Y:  viewer_q[1] <= cfg_data;
				d3bl_pkg::REG_VIEWER_Z:  viewer_q[2] <= cfg_data;
				d3bl_pkg::REG_SHININESS: shin_q      <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// stage control: a stage advances when empty or when the one after it advances
	logic [NS:1]   vld_s;
	logic [NS:1]   vld_prev;
	logic [NS+1:1] adv;

	assign vld_prev = {vld_s[NS-1:1], in_valid};

	always_comb begin
		adv[NS+1] = out_ready;
		for (int k = NS; k >= 1; k--) begin
			adv[k] = ~vld_s[k] | adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (adv[k]) vld_s[k] <= vld_prev[k];
			end
		end
	end

	assign in_ready  = adv[1];
	assign out_valid = vld_s[NS];

	// sideband travels with the item
	d3bl_pkg::side_t side_s [1:NS];

	always_ff @(posedge clk) begin
		if (adv[1]) side_s[1] <= {normal_xyz, tangent_xyz, binormal_xyz, last_vertex};
		for (int k = 2; k <= NS; k++) begin
			if (adv[k]) side_s[k] <= side_s[k-1];
		end
	end

	// stage 1: difference vectors as sign and magnitude
	logic signed [31:0] pos_c [3];
	logic signed [32:0] dif_c [2][3];
	logic [32:0]        mag_s1 [2][3];
	logic [2:0]         neg_s1 [2];

	assign pos_c[0] = pos_x;
	assign pos_c[1] = pos_y;
	assign pos_c[2] = pos_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dif_c[0][i] = 33'(light_q[i]) - 33'(pos_c[i]);
			dif_c[1][i] = 33'(viewer_q[i]) - 33'(pos_c[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[S_DIFF]) begin
			for (int j = 0; j < 2; j++) begin
				for (int i = 0; i < 3; i++) begin
					neg_s1[j][i] <= dif_c[j][i][32];
					mag_s1[j][i] <= dif_c[j][i][32] ? 33'(-dif_c[j][i]) : 33'(dif_c[j][i]);
				end
			end
		end
	end

	// stage 2: leading one of the largest magnitude
	logic [32:0] mag_s2 [2][3];
	logic [2:0]  neg_s2 [2];
	logic [5:0]  pos_s2 [2];
	logic        zero_s2 [2];

	always_ff @(posedge clk) begin
		if (adv[S_POS]) begin
			for (int j = 0; j < 2; j++) begin
				mag_s2[j]  <= mag_s1[j];
				neg_s2[j]  <= neg_s1[j];
				pos_s2[j]  <= d3bl_pkg::msb_pos(mag_s1[j][0] | mag_s1[j][1] | mag_s1[j][2]);
				zero_s2[j] <= ~|(mag_s1[j][0] | mag_s1[j][1] | mag_s1[j][2]);
			end
		end
	end

	// stage 3: bring the largest magnitude into [2^20, 2^21)
	d3bl_pkg::lane_t lane_s3 [2];

	always_ff @(posedge clk) begin
		if (adv[S_SHIFT]) begin
			for (int j = 0; j < 2; j++) begin
				lane_s3[j].neg  <= neg_s2[j];
				lane_s3[j].zero <= zero_s2[j];
				for (int i = 0; i < 3; i++) begin
					if (pos_s2[j] >= d3bl_pkg::NORM_MSB)
						lane_s3[j].a[i] <= 21'(mag_s2[j][i] >> (pos_s2[j] - d3bl_pkg::NORM_MSB));
					else
						lane_s3[j].a[i] <= 21'(mag_s2[j][i] << (d3bl_pkg::NORM_MSB - pos_s2[j]));
				end
			end
		end
	end

	// stage 4 and 5: sum of squares
	d3bl_pkg::lane_t lane_s4 [2];
	d3bl_pkg::lane_t lane_s5 [2];
	logic [41:0]     sq_s4 [2][3];
	logic [43:0]     sum_s5 [2];

	always_ff @(posedge clk) begin
		if (adv[S_SQR]) begin
			for (int j = 0; j < 2; j++) begin
				lane_s4[j] <= lane_s3[j];
				for (int i = 0; i < 3; i++) begin
					sq_s4[j][i] <= 42'(lane_s3[j].a[i]) * 42'(lane_s3[j].a[i]);
				end
			end
		end
		if (adv[S_SUM]) begin
			for (int j = 0; j < 2; j++) begin
				lane_s5[j] <= lane_s4[j];
				sum_s5[j]  <= 44'(sq_s4[j][0]) + 44'(sq_s4[j][1]) + 44'(sq_s4[j][2]);
			end
		end
	end

	// square root, two result bits per stage
	d3bl_pkg::root_t root_s [d3bl_pkg::SQ_STAGES][2];
	d3bl_pkg::lane_t rlane_s [d3bl_pkg::SQ_STAGES][2];

	for (genvar k = 0; k < d3bl_pkg::SQ_STAGES; k++) begin : g_root
		localparam int SH = 42 - 4 * k;
		d3bl_pkg::root_t src [2];
		d3bl_pkg::root_t mid [2];
		d3bl_pkg::root_t nxt [2];
		d3bl_pkg::lane_t lsrc [2];

		always_comb begin
			for (int j = 0; j < 2; j++) begin
				if (k == 0) begin
					src[j].n   = d3bl_pkg::SQ_W'(sum_s5[j]);
					src[j].res = '0;
					lsrc[j]    = lane_s5[j];
				end else begin
					src[j]  = root_s[(k == 0) ? 0 : k-1][j];
					lsrc[j] = rlane_s[(k == 0) ? 0 : k-1][j];
				end
				mid[j] = d3bl_pkg::root_step(src[j], d3bl_pkg::SQ_W'(1) << SH);
				nxt[j] = d3bl_pkg::root_step(mid[j], d3bl_pkg::SQ_W'(1) << (SH - 2));
			end
		end

		always_ff @(posedge clk) begin
			if (adv[S_ROOT0+k]) begin
				root_s[k]  <= nxt;
				rlane_s[k] <= lsrc;
			end
		end
	end

	// restoring divide, two quotient bits per stage except the last, which resolves one
	d3bl_pkg::quo_t quo_s [d3bl_pkg::DIV_STAGES][2];

	for (genvar k = 0; k < d3bl_pkg::DIV_STAGES; k++) begin : g_div
		localparam int unsigned SA = 16 - 2 * k;
		d3bl_pkg::quo_t src [2];
		d3bl_pkg::quo_t mid [2];
		d3bl_pkg::quo_t nxt [2];

		always_comb begin
			for (int j = 0; j < 2; j++) begin
				if (k == 0) begin
					src[j].neg  = rlane_s[d3bl_pkg::SQ_STAGES-1][j].neg;
					src[j].zero = rlane_s[d3bl_pkg::SQ_STAGES-1][j].zero;
					src[j].len  = root_s[d3bl_pkg::SQ_STAGES-1][j].res[22:0];
					for (int i = 0; i < 3; i++) begin
						src[j].rem[i] = {3'b000, rlane_s[d3bl_pkg::SQ_STAGES-1][j].a[i], 16'h0000};
						src[j].q[i]   = '0;
					end
				end else begin
					src[j] = quo_s[(k == 0) ? 0 : k-1][j];
				end
				mid[j] = d3bl_pkg::div_step(src[j], SA);
			end
		end

		if (SA >= 1) begin : g_two
			always_comb begin
				for (int j = 0; j < 2; j++) nxt[j] = d3bl_pkg::div_step(mid[j], SA - 1);
			end
		end else begin : g_one
			assign nxt = mid;
		end

		always_ff @(posedge clk) begin
			if (adv[S_DIV0+k]) quo_s[k] <= nxt;
		end
	end

	// unit vectors with sign restored, and their sum
	logic signed [17:0] ucmp_c [2][3];
	logic signed [17:0] lu_s [3];
	logic signed [17:0] vu_s [3];
	logic signed [18:0] hu_s [3];

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			for (int i = 0; i < 3; i++) begin
				if (quo_s[d3bl_pkg::DIV_STAGES-1][j].zero)
					ucmp_c[j][i] = '0;
				else if (quo_s[d3bl_pkg::DIV_STAGES-1][j].neg[i])
					ucmp_c[j][i] = -signed'(18'(quo_s[d3bl_pkg::DIV_STAGES-1][j].q[i]));
				else
					ucmp_c[j][i] = signed'(18'(quo_s[d3bl_pkg::DIV_STAGES-1][j].q[i]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[S_UNIT]) begin
			for (int i = 0; i < 3; i++) begin
				lu_s[i] <= ucmp_c[0][i];
				vu_s[i] <= ucmp_c[1][i];
				hu_s[i] <= 19'(ucmp_c[0][i]) + 19'(ucmp_c[1][i]);
			end
		end
	end

	// products against the frame vectors
	logic signed [15:0] nrm_c [3];
	logic signed [15:0] tan_c [3];
	logic signed [15:0] bin_c [3];
	logic signed [33:0] pln_s [3];
	logic signed [33:0] plt_s [3];
	logic signed [33:0] plb_s [3];
	logic signed [33:0] pvn_s [3];
	logic signed [34:0] pht_s [3];
	logic signed [34:0] phb_s [3];
	logic signed [34:0] phn_s [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nrm_c[i] = signed'(side_s[S_UNIT].nrm[16*i +: 16]);
			tan_c[i] = signed'(side_s[S_UNIT].tan[16*i +: 16]);
			bin_c[i] = signed'(side_s[S_UNIT].bin[16*i +: 16]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[S_MUL]) begin
			for (int i = 0; i < 3; i++) begin
				pln_s[i] <= 34'(lu_s[i]) * 34'(nrm_c[i]);
				plt_s[i] <= 34'(lu_s[i]) * 34'(tan_c[i]);
				plb_s[i] <= 34'(lu_s[i]) * 34'(bin_c[i]);
				pvn_s[i] <= 34'(vu_s[i]) * 34'(nrm_c[i]);
				pht_s[i] <= 35'(hu_s[i]) * 35'(tan_c[i]);
				phb_s[i] <= 35'(hu_s[i]) * 35'(bin_c[i]);
				phn_s[i] <= 35'(hu_s[i]) * 35'(nrm_c[i]);
			end
		end
	end

	// dot products
	logic signed [35:0] dln_s, dlt_s, dlb_s, dvn_s;
	logic signed [36:0] dht_s, dhb_s, dhn_s;

	always_ff @(posedge clk) begin
		if (adv[S_DOT]) begin
			dln_s <= 36'(pln_s[0]) + 36'(pln_s[1]) + 36'(pln_s[2]);
			dlt_s <= 36'(plt_s[0]) + 36'(plt_s[1]) + 36'(plt_s[2]);
			dlb_s <= 36'(plb_s[0]) + 36'(plb_s[1]) + 36'(plb_s[2]);
			dvn_s <= 36'(pvn_s[0]) + 36'(pvn_s[1]) + 36'(pvn_s[2]);
			dht_s <= 37'(pht_s[0]) + 37'(pht_s[1]) + 37'(pht_s[2]);
			dhb_s <= 37'(phb_s[0]) + 37'(phb_s[1]) + 37'(phb_s[2]);
			dhn_s <= 37'(phn_s[0]) + 37'(phn_s[1]) + 37'(phn_s[2]);
		end
	end

	// scale: diffuse by 127 plus bias, specular by shininess
	logic signed [43:0] td_s [3];
	logic signed [54:0] ps_s [3];
	logic               lit_s;
	logic signed [17:0] shin_c;
	logic signed [43:0] diff_bias_c;

	assign shin_c      = signed'(18'(shin_q));
	assign diff_bias_c = signed'(44'(1) << 37);

	always_ff @(posedge clk) begin
		if (adv[S_SCALE]) begin
			td_s[0] <= (44'(dlt_s) <<< 7) - 44'(dlt_s) + diff_bias_c;
			td_s[1] <= (44'(dlb_s) <<< 7) - 44'(dlb_s) + diff_bias_c;
			td_s[2] <= (44'(dln_s) <<< 7) - 44'(dln_s) + diff_bias_c;
			ps_s[0] <= 55'(dht_s) * 55'(shin_c);
			ps_s[1] <= 55'(dhb_s) * 55'(shin_c);
			ps_s[2] <= 55'(dhn_s) * 55'(shin_c);
			lit_s   <= ~dln_s[35] & ~dvn_s[35];
		end
	end

	// output register: bytes, or grey when facing away
	logic signed [57:0] spec_bias_c;
	logic [7:0]         db_c [3];
	logic [7:0]         sb_c [3];

	assign spec_bias_c = signed'(58'(1) << 55);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			db_c[i] = lit_s ? d3bl_pkg::diff_byte(td_s[i]) : d3bl_pkg::GREY_BYTE;
			sb_c[i] = lit_s ? d3bl_pkg::spec_byte(58'(ps_s[i]) + spec_bias_c)
			                : d3bl_pkg::GREY_BYTE;
		end
	end

	logic [7:0] dr_s, dg_s, db_s, sr_s, sg_s, sbb_s;
	logic       lit_o_s;

	always_ff @(posedge clk) begin
		if (adv[S_OUT]) begin
			dr_s    <= db_c[0];
			dg_s    <= db_c[1];
			db_s    <= db_c[2];
			sr_s    <= sb_c[0];
			sg_s    <= sb_c[1];
			sbb_s   <= sb_c[2];
			lit_o_s <= lit_s;
		end
	end

	assign diffuse_r  = dr_s;
	assign diffuse_g  = dg_s;
	assign diffuse_b  = db_s;
	assign specular_r = sr_s;
	assign specular_g = sg_s;
	assign specular_b = sbb_s;
	assign lit        = lit_o_s;
	assign last_out   = side_s[NS].last;

endmodule

### hw/rtl/d3bl_checker.sv
// Port-level checks of the DOT3 light vector core, bound to the top level.
`timescale 1ns / 1ps
module d3bl_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [7:0]         diffuse_r,
	input logic [7:0]         diffuse_g,
	input logic [7:0]         diffuse_b,
	input logic [7:0]         specular_r,
	input logic [7:0]         specular_g,
	input logic [7:0]         specular_b,
	input logic               lit,
	input logic               last_out
);

	// a stalled result holds (checked on diffuse_r, specular_b, lit and last_out)
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(diffuse_r) && $stable(specular_b)
		&& $stable(lit) && $stable(last_out))
		else $error("stalled result changed");

	// an empty output slot never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with output empty");

	// a draining output frees the input
	a_ready_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output drains");

	// grey result carries mid grey in every channel
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !lit |-> diffuse_r == d3bl_pkg::GREY_BYTE
		&& diffuse_g == d3bl_pkg::GREY_BYTE && diffuse_b == d3bl_pkg::GREY_BYTE
		&& specular_r == d3bl_pkg::GREY_BYTE && specular_g == d3bl_pkg::GREY_BYTE
		&& specular_b == d3bl_pkg::GREY_BYTE)
		else $error("unlit result not grey");

endmodule

bind dot3_bump_light_vector_core d3bl_checker u_d3bl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.diffuse_r  (diffuse_r),
	.diffuse_g  (diffuse_g),
	.diffuse_b  (diffuse_b),
	.specular_r (specular_r),
	.specular_g (specular_g),
	.specular_b (specular_b),
	.lit        (lit),
	.last_out   (last_out)
);
